@@ rtl/fgn_pkg.sv @@
// Shared types, constants and microcode for the fractal gradient noise unit.
`default_nettype none

package fgn_pkg;

   // Fixed-point format and limits
   localparam int FRAC_BITS   = 16;
   localparam int QONE        = 1 << FRAC_BITS;
   localparam int MAX_OCTAVES = 8;
   localparam int TABLE_SIZE  = 256;
   localparam int TABLE_AW    = $clog2(TABLE_SIZE);

   // Input operation codes
   typedef enum logic [1:0] {
      OP_TABLE_WRITE = 2'd0,
      OP_NOISE_2D    = 2'd1,
      OP_NOISE_3D    = 2'd2,
      OP_RIDGED_2D   = 2'd3
   } op_type;

   // Configuration register indexes
   typedef enum logic [1:0] {
      CSR_PERSISTENCE = 2'd0,
      CSR_LACUNARITY  = 2'd1,
      CSR_SPARE2      = 2'd2,
      CSR_SPARE3      = 2'd3
   } csr_index_type;

   localparam logic [15:0] PERSISTENCE_RESET = 16'd32768;
   localparam logic [19:0] LACUNARITY_RESET  = 20'd131072;

   // Datapath micro-operations; MUL_* loads the shared multiplier, WB_* retires it
   typedef enum logic [4:0] {
      UOP_NOP,
      UOP_MUL_S,   UOP_WB_S,
      UOP_MUL_F,   UOP_WB_F,
      UOP_MUL_A,   UOP_WB_A,
      UOP_MUL_P,   UOP_WB_P,
      UOP_MUL_FD1, UOP_WB_FD1,
      UOP_MUL_FD2, UOP_WB_FD2,
      UOP_MUL_FD3, UOP_WB_FD3,
      UOP_MUL_FD4, UOP_WB_FD4,
      UOP_RD_X,    UOP_CAP_X,
      UOP_RD_XY,   UOP_CAP_XY,
      UOP_RD_XYZ,  UOP_CAP_XYZ,
      UOP_GRAD,
      UOP_MUL_LRP, UOP_WB_LRP,
      UOP_MUL_ACC, UOP_WB_ACC,
      UOP_END
   } uop_type;

   typedef struct packed {
      uop_type    uop;
      logic [2:0] idx;
      logic [1:0] lvl;
      logic       only_3d;
   } uinstr_type;

   // Command bundle from controller to datapath
   typedef struct packed {
      uop_type    uop;
      logic [2:0] idx;
      logic [1:0] lvl;
      op_type     mode;
      logic       load_item;
      logic       table_write;
      logic       load_rsp;
   } cmd_type;

   // Program layout
   localparam int PC_W = 7;
   localparam logic [PC_W-1:0] PC_UPD  = 7'd6;
   localparam logic [PC_W-1:0] PC_BODY = 7'd10;
   localparam logic [PC_W-1:0] PC_FADE = 7'd16;
   localparam logic [PC_W-1:0] PC_HX   = 7'd40;
   localparam logic [PC_W-1:0] PC_HXY  = 7'd44;
   localparam logic [PC_W-1:0] PC_HXYZ = 7'd52;
   localparam logic [PC_W-1:0] PC_GRAD = 7'd68;
   localparam logic [PC_W-1:0] PC_LRP  = 7'd76;
   localparam logic [PC_W-1:0] PC_ACC  = 7'd90;
   localparam logic [PC_W-1:0] PC_END  = 7'd92;

   // Microcode ROM: scale, octave update, octave body
   function automatic uinstr_type ucode_fetch(input logic [PC_W-1:0] pc);
      uinstr_type      ui;
      logic [PC_W-1:0] o;
      ui.uop     = UOP_NOP;
      ui.idx     = 3'd0;
      ui.lvl     = 2'd0;
      ui.only_3d = 1'b0;
      o          = '0;
      if (pc < PC_UPD) begin
         o      = pc;
         ui.uop = o[0] ? UOP_WB_S : UOP_MUL_S;
         ui.idx = {1'b0, o[2:1]};
      end else if (pc < PC_BODY) begin
         o = pc - PC_UPD;
         case (o[1:0])
            2'd0:    ui.uop = UOP_MUL_F;
            2'd1:    ui.uop = UOP_WB_F;
            2'd2:    ui.uop = UOP_MUL_A;
            default: ui.uop = UOP_WB_A;
         endcase
      end else if (pc < PC_FADE) begin
         o          = pc - PC_BODY;
         ui.uop     = o[0] ? UOP_WB_P : UOP_MUL_P;
         ui.idx     = {1'b0, o[2:1]};
         ui.only_3d = (o[2:1] == 2'd2);
      end else if (pc < PC_HX) begin
         o          = pc - PC_FADE;
         ui.idx     = {1'b0, o[4:3]};
         ui.only_3d = (o[4:3] == 2'd2);
         case (o[2:0])
            3'd0:    ui.uop = UOP_MUL_FD1;
            3'd1:    ui.uop = UOP_WB_FD1;
            3'd2:    ui.uop = UOP_MUL_FD2;
            3'd3:    ui.uop = UOP_WB_FD2;
            3'd4:    ui.uop = UOP_MUL_FD3;
            3'd5:    ui.uop = UOP_WB_FD3;
            3'd6:    ui.uop = UOP_MUL_FD4;
            default: ui.uop = UOP_WB_FD4;
         endcase
      end else if (pc < PC_HXY) begin
         o      = pc - PC_HX;
         ui.uop = o[0] ? UOP_CAP_X : UOP_RD_X;
         ui.idx = {2'b0, o[1]};
      end else if (pc < PC_HXYZ) begin
         o      = pc - PC_HXY;
         ui.uop = o[0] ? UOP_CAP_XY : UOP_RD_XY;
         ui.idx = {1'b0, o[2:1]};
      end else if (pc < PC_GRAD) begin
         o          = pc - PC_HXYZ;
         ui.uop     = o[0] ? UOP_CAP_XYZ : UOP_RD_XYZ;
         ui.idx     = o[3:1];
         ui.only_3d = 1'b1;
      end else if (pc < PC_LRP) begin
         o          = pc - PC_GRAD;
         ui.uop     = UOP_GRAD;
         ui.idx     = o[2:0];
         ui.only_3d = o[2];
      end else if (pc < PC_ACC) begin
         o      = pc - PC_LRP;
         ui.uop = o[0] ? UOP_WB_LRP : UOP_MUL_LRP;
         // blend tree: four x-blends, two y-blends, one z-blend
         case (o[3:1])
            3'd0:    begin ui.idx = 3'd0; ui.lvl = 2'd0; end
            3'd1:    begin ui.idx = 3'd1; ui.lvl = 2'd0; end
            3'd2:    begin ui.idx = 3'd2; ui.lvl = 2'd0; ui.only_3d = 1'b1; end
            3'd3:    begin ui.idx = 3'd3; ui.lvl = 2'd0; ui.only_3d = 1'b1; end
            3'd4:    begin ui.idx = 3'd0; ui.lvl = 2'd1; end
            3'd5:    begin ui.idx = 3'd1; ui.lvl = 2'd1; ui.only_3d = 1'b1; end
            default: begin ui.idx = 3'd0; ui.lvl = 2'd2; ui.only_3d = 1'b1; end
         endcase
      end else if (pc == PC_ACC) begin
         ui.uop = UOP_MUL_ACC;
      end else if (pc < PC_END) begin
         ui.uop = UOP_WB_ACC;
      end else begin
         ui.uop = UOP_END;
      end
      return ui;
   endfunction

endpackage

`default_nettype wire

@@ rtl/fractal_gradient_noise_unit.sv @@
// Top level of the fractal gradient noise unit.
//
//  channel  ports                                   transfer when
//  req      req_valid/req_stall + item fields       req_valid && !req_stall
//  rsp      rsp_valid/rsp_stall + noise, saturated  rsp_valid && !rsp_stall
//  csr      csr_valid/csr_ready + index, data       csr_valid && csr_ready
//
//  A table write is done when it transfers. An evaluate item holds req_stall until its
//  result is loaded, while one shared 33x33 multiplier and one permutation memory read port
//  are stepped by a microcode sequencer.
//  Reset (synchronous) restores persistence and lacunarity; the table is not cleared.
//  A finished result waits in the output register while the next item is taken.
`default_nettype none

module fractal_gradient_noise_unit
   import fgn_pkg::*;
(
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   output logic                    req_stall,
   input  wire logic [1:0]         req_operation,
   input  wire logic [7:0]         req_table_index,
   input  wire logic [7:0]         req_table_value,
   input  wire logic signed [31:0] req_coord_x,
   input  wire logic signed [31:0] req_coord_y,
   input  wire logic signed [31:0] req_coord_z,
   input  wire logic [23:0]        req_coord_scale,
   input  wire logic [3:0]         req_octave_count,
   output logic                    rsp_valid,
   input  wire logic               rsp_stall,
   output logic signed [31:0]      rsp_noise_value,
   output logic                    rsp_saturated,
   input  wire logic               csr_valid,
   output logic                    csr_ready,
   input  wire logic [1:0]         csr_index,
   input  wire logic [19:0]        csr_data
);

   cmd_type cmd;

   assign csr_ready = 1'b1;

   fgn_ctrl u_ctrl (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_operation    (req_operation),
      .req_octave_count (req_octave_count),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .cmd              (cmd)
   );

   fgn_datapath u_datapath (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .req_table_index (req_table_index),
      .req_table_value (req_table_value),
      .req_coord_x     (req_coord_x),
      .req_coord_y     (req_coord_y),
      .req_coord_z     (req_coord_z),
      .req_coord_scale (req_coord_scale),
      .csr_valid       (csr_valid),
      .csr_index       (csr_index),
      .csr_data        (csr_data),
      .rsp_noise_value (rsp_noise_value),
      .rsp_saturated   (rsp_saturated)
   );

endmodule

`default_nettype wire

@@ rtl/fgn_ctrl.sv @@
// Sequencer for the noise unit: handshakes, program counter and octave loop.
`default_nettype none

module fgn_ctrl
   import fgn_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   output logic            req_stall,
   input  wire logic [1:0] req_operation,
   input  wire logic [3:0] req_octave_count,
   output logic            rsp_valid,
   input  wire logic       rsp_stall,
   output cmd_type         cmd
);

   typedef enum logic [2:0] {
      ST_IDLE   = 3'b001,
      ST_RUN    = 3'b010,
      ST_FINISH = 3'b100
   } state_type;

   localparam logic [3:0] OCT_MAX = 4'(MAX_OCTAVES);

   state_type       state_ff, state_in;
   logic [PC_W-1:0] pc_ff, pc_in;
   logic [3:0]      oct_ff, oct_in;
   logic [3:0]      cnt_ff, cnt_in;
   op_type          mode_ff, mode_in;
   logic            rsp_valid_ff, rsp_valid_in;

   uinstr_type ui;
   logic       skip_upd;
   logic       skip_3d;

   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

   // Next-state and command decode
   always_comb begin
      logic [3:0] oct_next;
      ui       = ucode_fetch(pc_ff);
      skip_upd = (pc_ff == PC_UPD) && (oct_ff == 4'd0);
      skip_3d  = ui.only_3d && (mode_ff != OP_NOISE_3D);
      oct_next = oct_ff + 4'd1;

      state_in = state_ff;
      pc_in    = pc_ff;
      oct_in   = oct_ff;
      cnt_in   = cnt_ff;
      mode_in  = mode_ff;

      cmd.uop         = UOP_NOP;
      cmd.idx         = ui.idx;
      cmd.lvl         = ui.lvl;
      cmd.mode        = mode_ff;
      cmd.load_item   = 1'b0;
      cmd.table_write = 1'b0;
      cmd.load_rsp    = 1'b0;

      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               if (op_type'(req_operation) == OP_TABLE_WRITE) begin
                  cmd.table_write = 1'b1;
               end else begin
                  cmd.load_item = 1'b1;
                  mode_in       = op_type'(req_operation);
                  cnt_in        = (req_octave_count > OCT_MAX) ? OCT_MAX : req_octave_count;
                  oct_in        = 4'd0;
                  pc_in         = '0;
                  state_in      = ST_RUN;
               end
            end
         end
         ST_RUN: begin
            if (!skip_upd && !skip_3d) begin
               cmd.uop = ui.uop;
            end
            if (skip_upd) begin
               // first octave runs at unit frequency and amplitude
               if (cnt_ff == 4'd0) begin
                  state_in = ST_FINISH;
               end else begin
                  pc_in = PC_BODY;
               end
            end else if (ui.uop == UOP_END) begin
               if (oct_next == cnt_ff) begin
                  state_in = ST_FINISH;
               end else begin
                  oct_in = oct_next;
                  pc_in  = PC_UPD;
               end
            end else begin
               pc_in = pc_ff + 7'd1;
            end
         end
         ST_FINISH: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               cmd.load_rsp = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      rsp_valid_in = cmd.load_rsp || (rsp_valid_ff && rsp_stall);
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         pc_ff        <= '0;
         oct_ff       <= 4'd0;
         cnt_ff       <= 4'd0;
         mode_ff      <= OP_NOISE_2D;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         pc_ff        <= pc_in;
         oct_ff       <= oct_in;
         cnt_ff       <= cnt_in;
         mode_ff      <= mode_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Checks
   a_rsp_slot_free: assert property (@(posedge clock) disable iff (reset)
      cmd.load_rsp |-> (!rsp_valid_ff || !rsp_stall))
      else $error("result loaded over a pending result");

   a_eval_start: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall && (req_operation != OP_TABLE_WRITE))
      |=> (state_ff == ST_RUN && pc_ff == '0))
      else $error("evaluate transfer did not start the program");

   a_pc_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_RUN) |-> (pc_ff <= PC_END))
      else $error("program counter out of range");

   a_oct_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_RUN) |-> ((oct_ff < cnt_ff) || (oct_ff == 4'd0 && cnt_ff == 4'd0)))
      else $error("octave counter past octave count");

endmodule

`default_nettype wire

@@ rtl/fgn_datapath.sv @@
// Noise datapath: shared multiplier, permutation memory, working registers.
`default_nettype none

module fgn_datapath
   import fgn_pkg::*;
(
   input  wire logic               clock,
   input  wire logic               reset,
   input  cmd_type                 cmd,
   input  wire logic [7:0]         req_table_index,
   input  wire logic [7:0]         req_table_value,
   input  wire logic signed [31:0] req_coord_x,
   input  wire logic signed [31:0] req_coord_y,
   input  wire logic signed [31:0] req_coord_z,
   input  wire logic [23:0]        req_coord_scale,
   input  wire logic               csr_valid,
   input  wire logic [1:0]         csr_index,
   input  wire logic [19:0]        csr_data,
   output logic signed [31:0]      rsp_noise_value,
   output logic                    rsp_saturated
);

   localparam logic [21:0] Q15 = 22'(15 * QONE);
   localparam logic [23:0] Q10 = 24'(10 * QONE);
   localparam logic [24:0] Q25 = 25'(QONE);

   // Clamp to signed 32 bits; top bit flags saturation
   function automatic logic [32:0] sat32(input logic signed [50:0] v);
      if (v > 51'sd2147483647) begin
         return {1'b1, 32'h7FFF_FFFF};
      end else if (v < -51'sd2147483648) begin
         return {1'b1, 32'h8000_0000};
      end
      return {1'b0, v[31:0]};
   endfunction

   logic [15:0]        persist_ff;
   logic [19:0]        lacun_ff;

   logic signed [31:0] coord_ff [0:2];
   logic [23:0]        scale_ff;
   logic signed [31:0] s_ff [0:2];
   logic [31:0]        freq_ff;
   logic [16:0]        amp_ff;
   logic signed [31:0] sum_ff;
   logic               sat_ff;
   logic [15:0]        frac_ff [0:2];
   logic [7:0]         cell_ff [0:2];
   logic signed [23:0] fa_ff;
   logic [16:0]        fb_ff;
   logic signed [17:0] fade_ff [0:2];
   logic [7:0]         hx_ff [0:1];
   logic [7:0]         hxy_ff [0:3];
   logic [7:0]         hxyz_ff [0:7];
   logic signed [23:0] g_ff [0:7];
   logic signed [23:0] la_ff;
   logic signed [65:0] prod_ff;
   logic signed [31:0] rsp_noise_ff;
   logic               rsp_sat_ff;

   logic [7:0]         perm_mem [0:TABLE_SIZE-1];
   logic [7:0]         rd_data_ff;
   logic [7:0]         rd_addr;

   logic signed [32:0] mul_a, mul_b;
   logic signed [49:0] q;
   logic [15:0]        t;
   logic [21:0]        t6m;
   logic signed [19:0] grad;
   logic signed [24:0] nrm;
   logic [32:0]        sat_w;

   assign q               = prod_ff[65:FRAC_BITS];
   assign t               = frac_ff[cmd.idx[1:0]];
   assign rsp_noise_value = rsp_noise_ff;
   assign rsp_saturated   = rsp_sat_ff;

   // Inner fade term 6t - 15
   always_comb begin
      logic [21:0] tw;
      tw  = {6'b0, t};
      t6m = (tw << 2) + (tw << 1) - Q15;
   end

   // Gradient of one lattice corner
   always_comb begin
      logic [7:0]         h;
      logic signed [19:0] gx, gy, gz, u, v;
      h  = (cmd.mode == OP_NOISE_3D) ? hxyz_ff[cmd.idx] : hxy_ff[cmd.idx[1:0]];
      gx = $signed({4'b0, frac_ff[0]}) - (cmd.idx[0] ? 20'sd65536 : 20'sd0);
      gy = $signed({4'b0, frac_ff[1]}) - (cmd.idx[1] ? 20'sd65536 : 20'sd0);
      gz = $signed({4'b0, frac_ff[2]}) - (cmd.idx[2] ? 20'sd65536 : 20'sd0);
      if (cmd.mode == OP_NOISE_3D) begin
         u = (h[3:0] < 4'd8) ? gx : gy;
         if (h[3:0] < 4'd4) begin
            v = gy;
         end else if (h[3:0] inside {4'd12, 4'd14}) begin
            v = gx;
         end else begin
            v = gz;
         end
         grad = (h[0] ? -u : u) + (h[1] ? -v : v);
      end else begin
         u    = (h[2:0] < 3'd4) ? gx : gy;
         v    = (h[2:0] < 3'd4) ? gy : gx;
         grad = (h[0] ? -u : u) + (h[1] ? -(v <<< 1) : (v <<< 1));
      end
   end

   // Octave term before amplitude: plain or ridged
   always_comb begin
      logic signed [24:0] g0, mag;
      g0  = 25'(g_ff[0]);
      mag = (g0 < 0) ? -g0 : g0;
      nrm = (cmd.mode == OP_RIDGED_2D) ? ($signed(Q25) - mag) : g0;
   end

   // Multiplier operand select
   always_comb begin
      logic signed [24:0] diff;
      diff  = 25'(g_ff[{cmd.idx[1:0], 1'b1}]) - 25'(g_ff[{cmd.idx[1:0], 1'b0}]);
      mul_a = '0;
      mul_b = '0;
      case (cmd.uop)
         UOP_MUL_S: begin
            mul_a = 33'(coord_ff[cmd.idx[1:0]]);
            mul_b = $signed({9'b0, scale_ff});
         end
         UOP_MUL_F: begin
            mul_a = $signed({1'b0, freq_ff});
            mul_b = $signed({13'b0, lacun_ff});
         end
         UOP_MUL_A: begin
            mul_a = $signed({16'b0, amp_ff});
            mul_b = $signed({17'b0, persist_ff});
         end
         UOP_MUL_P: begin
            mul_a = 33'(s_ff[cmd.idx[1:0]]);
            mul_b = $signed({1'b0, freq_ff});
         end
         UOP_MUL_FD1: begin
            mul_a = $signed({17'b0, t});
            mul_b = 33'($signed(t6m));
         end
         UOP_MUL_FD2: begin
            mul_a = $signed({17'b0, t});
            mul_b = $signed({17'b0, t});
         end
         UOP_MUL_FD3: begin
            mul_a = $signed({16'b0, fb_ff});
            mul_b = $signed({17'b0, t});
         end
         UOP_MUL_FD4: begin
            mul_a = $signed({16'b0, fb_ff});
            mul_b = 33'(fa_ff);
         end
         UOP_MUL_LRP: begin
            mul_a = 33'(fade_ff[cmd.lvl]);
            mul_b = 33'(diff);
         end
         UOP_MUL_ACC: begin
            mul_a = 33'(nrm);
            mul_b = $signed({16'b0, amp_ff});
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   // Saturating result for the retire stages
   always_comb begin
      case (cmd.uop)
         UOP_WB_ACC: sat_w = sat32(51'(sum_ff) + 51'(q));
         default:    sat_w = sat32(51'(q));
      endcase
   end

   // Permutation memory address
   always_comb begin
      case (cmd.uop)
         UOP_RD_X:   rd_addr = cell_ff[0] + {7'b0, cmd.idx[0]};
         UOP_RD_XY:  rd_addr = hx_ff[cmd.idx[0]] + cell_ff[1] + {7'b0, cmd.idx[1]};
         UOP_RD_XYZ: rd_addr = hxy_ff[cmd.idx[1:0]] + cell_ff[2] + {7'b0, cmd.idx[2]};
         default:    rd_addr = '0;
      endcase
   end

   // Permutation memory
   always_ff @(posedge clock) begin
      if (cmd.table_write) begin
         perm_mem[req_table_index[TABLE_AW-1:0]] <= req_table_value;
      end
      rd_data_ff <= perm_mem[rd_addr];
   end

   // Configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         persist_ff <= PERSISTENCE_RESET;
         lacun_ff   <= LACUNARITY_RESET;
      end else if (csr_valid) begin
         case (csr_index_type'(csr_index))
            CSR_PERSISTENCE: persist_ff <= csr_data[15:0];
            CSR_LACUNARITY:  lacun_ff   <= csr_data;
            default:         ;
         endcase
      end
   end

   // Shared multiplier stage
   always_ff @(posedge clock) begin
      prod_ff <= mul_a * mul_b;
   end

   // Working registers
   always_ff @(posedge clock) begin
      if (cmd.load_item) begin
         coord_ff[0] <= req_coord_x;
         coord_ff[1] <= req_coord_y;
         coord_ff[2] <= req_coord_z;
         scale_ff    <= req_coord_scale;
         sum_ff      <= '0;
         sat_ff      <= 1'b0;
         freq_ff     <= 32'(QONE);
         amp_ff      <= 17'(QONE);
      end
      case (cmd.uop)
         UOP_WB_S: begin
            s_ff[cmd.idx[1:0]] <= sat_w[31:0];
            sat_ff             <= sat_ff | sat_w[32];
         end
         UOP_WB_F: begin
            if (cmd.mode == OP_RIDGED_2D) begin
               freq_ff <= {freq_ff[30:0], 1'b0};
            end else if (q[49:32] != '0) begin
               freq_ff <= 32'hFFFF_FFFF;
               sat_ff  <= 1'b1;
            end else begin
               freq_ff <= q[31:0];
            end
         end
         UOP_WB_A: begin
            amp_ff <= (cmd.mode == OP_RIDGED_2D) ? (amp_ff >> 1) : q[16:0];
         end
         UOP_WB_P: begin
            frac_ff[cmd.idx[1:0]] <= sat_w[FRAC_BITS-1:0];
            cell_ff[cmd.idx[1:0]] <= sat_w[FRAC_BITS+7:FRAC_BITS];
            sat_ff                <= sat_ff | sat_w[32];
         end
         UOP_WB_FD1: fa_ff <= q[23:0] + $signed(Q10);
         UOP_WB_FD2: fb_ff <= q[16:0];
         UOP_WB_FD3: fb_ff <= q[16:0];
         UOP_WB_FD4: fade_ff[cmd.idx[1:0]] <= q[17:0];
         UOP_CAP_X:   hx_ff[cmd.idx[0]]     <= rd_data_ff;
         UOP_CAP_XY:  hxy_ff[cmd.idx[1:0]]  <= rd_data_ff;
         UOP_CAP_XYZ: hxyz_ff[cmd.idx]      <= rd_data_ff;
         UOP_GRAD:    g_ff[cmd.idx]         <= 24'(grad);
         UOP_MUL_LRP: la_ff <= g_ff[{cmd.idx[1:0], 1'b0}];
         UOP_WB_LRP:  g_ff[{1'b0, cmd.idx[1:0]}] <= la_ff + q[23:0];
         UOP_WB_ACC: begin
            sum_ff <= sat_w[31:0];
            sat_ff <= sat_ff | sat_w[32];
         end
         default: ;
      endcase
   end

   // Result register
   always_ff @(posedge clock) begin
      if (cmd.load_rsp) begin
         rsp_noise_ff <= sum_ff;
         rsp_sat_ff   <= sat_ff;
      end
   end

endmodule

`default_nettype wire

@@ sim/tb.sv @@
// Self-checking testbench for the fractal gradient noise unit.
module tb;
   import fgn_pkg::*;

   localparam longint ONE_Q     = 64'sd65536;
   localparam longint FREQ_MAX  = 64'sd4294967295;
   localparam int     DRAIN_CYC = 800;

   typedef struct {
      op_type             op;
      logic [7:0]         tbl_index;
      logic [7:0]         tbl_value;
      logic signed [31:0] x;
      logic signed [31:0] y;
      logic signed [31:0] z;
      logic [23:0]        scale;
      logic [3:0]         octaves;
   } noise_req_type;

   typedef struct {
      logic signed [31:0] value;
      logic               sat;
   } noise_rsp_type;

   typedef struct {
      noise_req_type req;
      bit            typed;
      noise_rsp_type rsp;
   } directed_row_type;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_valid = 1'b0;
   logic               req_stall;
   logic [1:0]         req_operation = '0;
   logic [7:0]         req_table_index = '0;
   logic [7:0]         req_table_value = '0;
   logic signed [31:0] req_coord_x = '0;
   logic signed [31:0] req_coord_y = '0;
   logic signed [31:0] req_coord_z = '0;
   logic [23:0]        req_coord_scale = '0;
   logic [3:0]         req_octave_count = '0;
   logic               rsp_valid;
   logic               rsp_stall = 1'b0;
   logic signed [31:0] rsp_noise_value;
   logic               rsp_saturated;
   logic               csr_valid = 1'b0;
   logic [1:0]         csr_index = '0;
   logic [19:0]        csr_data = '0;
   logic               csr_ready;

   // Predictor state
   logic [7:0]  perm_shadow [TABLE_SIZE];
   logic [15:0] persist_shadow;
   logic [19:0] lacun_shadow;

   noise_rsp_type pending_noise [$];
   int            error_count = 0;
   bit            hold_request = 1'b0;

   fractal_gradient_noise_unit u_dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_operation    (req_operation),
      .req_table_index  (req_table_index),
      .req_table_value  (req_table_value),
      .req_coord_x      (req_coord_x),
      .req_coord_y      (req_coord_y),
      .req_coord_z      (req_coord_z),
      .req_coord_scale  (req_coord_scale),
      .req_octave_count (req_octave_count),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_noise_value  (rsp_noise_value),
      .rsp_saturated    (rsp_saturated),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_index        (csr_index),
      .csr_data         (csr_data)
   );

   always #5 clock = ~clock;

   // ---------------- fixed-point predictor ----------------
   function automatic longint qmul(longint a, longint b);
      return (a * b) >>> 16;
   endfunction

   function automatic longint clamp32(longint v, inout bit s);
      if (v > 64'sd2147483647) begin
         s = 1'b1;
         return 64'sd2147483647;
      end
      if (v < -64'sd2147483648) begin
         s = 1'b1;
         return -64'sd2147483648;
      end
      return v;
   endfunction

   function automatic int perm_at(int i);
      return int'(perm_shadow[i & 255]);
   endfunction

   function automatic longint fade(longint t);
      longint inner, t3;
      inner = qmul(t, 6 * t - 15 * ONE_Q) + 10 * ONE_Q;
      t3    = qmul(qmul(t, t), t);
      return qmul(t3, inner);
   endfunction

   function automatic longint blend(longint a, longint b, longint t);
      return a + qmul(t, b - a);
   endfunction

   function automatic longint grad_2d(int h, longint x, longint y);
      longint u, v;
      h = h & 7;
      u = (h < 4) ? x : y;
      v = (h < 4) ? y : x;
      return (((h & 1) != 0) ? -u : u) + (((h & 2) != 0) ? -2 * v : 2 * v);
   endfunction

   function automatic longint grad_3d(int h, longint x, longint y, longint z);
      longint u, v;
      h = h & 15;
      u = (h < 8) ? x : y;
      v = (h < 4) ? y : ((h == 12 || h == 14) ? x : z);
      return (((h & 1) != 0) ? -u : u) + (((h & 2) != 0) ? -v : v);
   endfunction

   function automatic int cell_of(longint p);
      return int'((p >>> 16) & 255);
   endfunction

   function automatic longint noise_2d(longint px, longint py);
      int     x0, y0;
      longint fx, fy, g00, g10, g01, g11;
      x0  = cell_of(px);
      y0  = cell_of(py);
      fx  = px & 64'hFFFF;
      fy  = py & 64'hFFFF;
      g00 = grad_2d(perm_at(perm_at(x0) + y0), fx, fy);
      g10 = grad_2d(perm_at(perm_at(x0 + 1) + y0), fx - ONE_Q, fy);
      g01 = grad_2d(perm_at(perm_at(x0) + y0 + 1), fx, fy - ONE_Q);
      g11 = grad_2d(perm_at(perm_at(x0 + 1) + y0 + 1), fx - ONE_Q, fy - ONE_Q);
      return blend(blend(g00, g10, fade(fx)), blend(g01, g11, fade(fx)), fade(fy));
   endfunction

   function automatic longint noise_3d(longint px, longint py, longint pz);
      int     x0, y0, z0, hx0, hx1, hx0y1, hx1y1, hx0y0, hx1y0;
      longint fx, fy, fz, gx, gy, gz, u, v, w, a0, a1;
      longint g000, g100, g010, g110, g001, g101, g011, g111;
      x0 = cell_of(px); y0 = cell_of(py); z0 = cell_of(pz);
      fx = px & 64'hFFFF; fy = py & 64'hFFFF; fz = pz & 64'hFFFF;
      gx = fx - ONE_Q; gy = fy - ONE_Q; gz = fz - ONE_Q;
      hx0   = perm_at(x0);
      hx1   = perm_at(x0 + 1);
      hx0y0 = perm_at(hx0 + y0);
      hx1y0 = perm_at(hx1 + y0);
      hx0y1 = perm_at(hx0 + y0 + 1);
      hx1y1 = perm_at(hx1 + y0 + 1);
      g000 = grad_3d(perm_at(hx0y0 + z0), fx, fy, fz);
      g100 = grad_3d(perm_at(hx1y0 + z0), gx, fy, fz);
      g010 = grad_3d(perm_at(hx0y1 + z0), fx, gy, fz);
      g110 = grad_3d(perm_at(hx1y1 + z0), gx, gy, fz);
      g001 = grad_3d(perm_at(hx0y0 + z0 + 1), fx, fy, gz);
      g101 = grad_3d(perm_at(hx1y0 + z0 + 1), gx, fy, gz);
      g011 = grad_3d(perm_at(hx0y1 + z0 + 1), fx, gy, gz);
      g111 = grad_3d(perm_at(hx1y1 + z0 + 1), gx, gy, gz);
      u = fade(fx); v = fade(fy); w = fade(fz);
      a0 = blend(blend(g000, g100, u), blend(g010, g110, u), v);
      a1 = blend(blend(g001, g101, u), blend(g011, g111, u), v);
      return blend(a0, a1, w);
   endfunction

   function automatic noise_rsp_type predict_noise(noise_req_type r);
      noise_rsp_type res;
      bit            s;
      longint        scl, sx, sy, sz, freq, amp, total, px, py, n;
      int            count;
      s     = 1'b0;
      total = 0;
      scl   = longint'({40'd0, r.scale});
      sx    = clamp32(qmul(longint'(r.x), scl), s);
      sy    = clamp32(qmul(longint'(r.y), scl), s);
      sz    = clamp32(qmul(longint'(r.z), scl), s);
      count = (r.octaves > MAX_OCTAVES) ? MAX_OCTAVES : int'(r.octaves);
      freq  = ONE_Q;
      amp   = ONE_Q;
      for (int i = 0; i < count; i++) begin
         if (i > 0) begin
            if (r.op == OP_RIDGED_2D) begin
               freq = freq * 2;
               amp  = amp >>> 1;
            end else begin
               freq = qmul(freq, longint'({44'd0, lacun_shadow}));
               if (freq > FREQ_MAX) begin
                  freq = FREQ_MAX;
                  s    = 1'b1;
               end
               amp = qmul(amp, longint'({48'd0, persist_shadow}));
            end
         end
         px = clamp32(qmul(sx, freq), s);
         py = clamp32(qmul(sy, freq), s);
         if (r.op == OP_NOISE_3D) begin
            n = noise_3d(px, py, clamp32(qmul(sz, freq), s));
         end else begin
            n = noise_2d(px, py);
            if (r.op == OP_RIDGED_2D) n = ONE_Q - ((n < 0) ? -n : n);
         end
         total = clamp32(total + qmul(n, amp), s);
      end
      res.value = total[31:0];
      res.sat   = s;
      return res;
   endfunction

   // ---------------- request side ----------------
   // Hold the item until its transfer, then update the shadow table or queue the result
   task automatic send_req(noise_req_type r, bit typed, noise_rsp_type typed_rsp);
      req_valid        <= 1'b1;
      req_operation    <= r.op;
      req_table_index  <= r.tbl_index;
      req_table_value  <= r.tbl_value;
      req_coord_x      <= r.x;
      req_coord_y      <= r.y;
      req_coord_z      <= r.z;
      req_coord_scale  <= r.scale;
      req_octave_count <= r.octaves;
      do @(posedge clock); while (req_stall);
      if (r.op == OP_TABLE_WRITE) perm_shadow[r.tbl_index] = r.tbl_value;
      else if (typed) pending_noise.insert(pending_noise.size(), typed_rsp);
      else pending_noise.insert(pending_noise.size(), predict_noise(r));
   endtask

   task automatic idle_req(int cycles);
      if (cycles > 0) begin
         req_valid <= 1'b0;
         repeat (cycles) @(posedge clock);
      end
   endtask

   // Register writes only with the unit drained
   task automatic write_csr(csr_index_type idx, logic [19:0] data);
      req_valid <= 1'b0;
      while (pending_noise.size() != 0) @(posedge clock);
      repeat (DRAIN_CYC) @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= data;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      if (idx == CSR_PERSISTENCE) persist_shadow = data[15:0];
      else if (idx == CSR_LACUNARITY) lacun_shadow = data;
   endtask

   function automatic noise_req_type make_req(op_type op, int x, int y, int z, int scl,
                                              int oct);
      noise_req_type r;
      r.op        = op;
      r.tbl_index = 8'd0;
      r.tbl_value = 8'd0;
      r.x         = x;
      r.y         = y;
      r.z         = z;
      r.scale     = scl[23:0];
      r.octaves   = oct[3:0];
      return r;
   endfunction

   function automatic noise_req_type random_req();
      noise_req_type r;
      if ($urandom_range(0, 9) == 0) begin
         r            = make_req(OP_TABLE_WRITE, $urandom, $urandom, $urandom, $urandom, 0);
         r.tbl_index  = $urandom_range(0, 255);
         r.tbl_value  = $urandom_range(0, 255);
         r.octaves    = $urandom_range(0, 15);
         return r;
      end
      r   = make_req(op_type'($urandom_range(1, 3)), 0, 0, 0, 0, 0);
      r.x = ($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(0, 32'h0080_0000) - 32'h0040_0000;
      r.y = ($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(0, 32'h0080_0000) - 32'h0040_0000;
      r.z = ($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(0, 32'h0080_0000) - 32'h0040_0000;
      r.scale = ($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(32'h4000, 32'h40000);
      r.octaves = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 15) : $urandom_range(1, 3);
      r.tbl_index = $urandom;
      r.tbl_value = $urandom;
      return r;
   endfunction

   // Bursts of transfers separated by random gaps
   task automatic random_phase(int count, int gap_max, bit with_hold);
      noise_rsp_type none;
      int            burst;
      none  = '{default: '0};
      burst = $urandom_range(1, 8);
      for (int i = 0; i < count; i++) begin
         if (with_hold && i == count / 3) hold_request = 1'b1;
         send_req(random_req(), 1'b0, none);
         burst--;
         if (burst == 0) begin
            idle_req($urandom_range(0, gap_max));
            burst = $urandom_range(1, 8);
         end
      end
   endtask

   // ---------------- stimulus ----------------
   initial begin
      directed_row_type rows [$];
      noise_rsp_type    none;
      noise_req_type    r;
      int               perm [256];
      int               j, tmp;

      none           = '{default: '0};
      persist_shadow = PERSISTENCE_RESET;
      lacun_shadow   = LACUNARITY_RESET;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Fill the whole table with a shuffled permutation before any read
      for (int i = 0; i < 256; i++) perm[i] = i;
      for (int i = 255; i > 0; i--) begin
         j       = $urandom_range(0, i);
         tmp     = perm[i];
         perm[i] = perm[j];
         perm[j] = tmp;
      end
      for (int i = 0; i < 256; i++) begin
         r           = make_req(OP_TABLE_WRITE, 0, 0, 0, 0, 0);
         r.tbl_index = i;
         r.tbl_value = perm[i];
         send_req(r, 1'b0, none);
      end

      // Directed rows: origin, zero octaves, extremes, table extremes
      rows.insert(rows.size(), '{make_req(OP_NOISE_2D, 0, 0, 0, 24'hFFFFFF, 1), 1,
                                 '{32'sd0, 1'b0}});
      rows.insert(rows.size(), '{make_req(OP_NOISE_3D, 0, 0, 0, 24'hFFFFFF, 1), 1,
                                 '{32'sd0, 1'b0}});
      rows.insert(rows.size(), '{make_req(OP_RIDGED_2D, 0, 0, 0, 24'h010000, 1), 1,
                                 '{32'sd65536, 1'b0}});
      rows.insert(rows.size(), '{make_req(OP_NOISE_2D, 32'h1234_5678, 7, 9, 24'h010000, 0), 1,
                                 '{32'sd0, 1'b0}});
      rows.insert(rows.size(), '{make_req(OP_NOISE_3D, -1, -1, -1, 24'hFFFFFF, 0), 1,
                                 '{32'sd0, 1'b0}});
      rows.insert(rows.size(), '{make_req(OP_RIDGED_2D, 5, 5, 5, 24'd5, 0), 1,
                                 '{32'sd0, 1'b0}});
      rows.insert(rows.size(), '{make_req(OP_NOISE_2D, 32'h7FFF_FFFF, 32'h8000_0000, 0,
                                          24'hFFFFFF, 1), 0, none});
      rows.insert(rows.size(), '{make_req(OP_NOISE_3D, 32'h8000_0000, 32'h7FFF_FFFF,
                                          32'h7FFF_FFFF, 24'hFFFFFF, 8), 0, none});
      rows.insert(rows.size(), '{make_req(OP_RIDGED_2D, 32'h0001_8000, 32'h0002_4000, 0,
                                          24'h010000, 15), 0, none});
      rows.insert(rows.size(), '{make_req(OP_NOISE_2D, 32'h0003_0000, 32'h0001_0000, 0,
                                          24'd0, 15), 0, none});
      rows.insert(rows.size(), '{make_req(OP_NOISE_3D, -1, -1, -1, 24'h010000, 3), 0, none});
      rows.insert(rows.size(), '{make_req(OP_NOISE_2D, 32'h7FFF_FFFF, 32'h0000_8000, 0,
                                          24'h010000, 8), 0, none});
      rows.insert(rows.size(), '{make_req(OP_RIDGED_2D, 32'h0000_8000, 32'hFFFE_8000, 0,
                                          24'hFFFFFF, 8), 0, none});
      rows.insert(rows.size(), '{make_req(OP_NOISE_3D, 32'h0012_3456, 32'hFFED_CBA9,
                                          32'h00FF_C000, 24'h028000, 4), 0, none});
      r = make_req(OP_TABLE_WRITE, 0, 0, 0, 0, 0);
      r.tbl_index = 8'hFF; r.tbl_value = 8'hFF;
      rows.insert(rows.size(), '{r, 0, none});
      r.tbl_index = 8'h00; r.tbl_value = 8'h00;
      rows.insert(rows.size(), '{r, 0, none});
      rows.insert(rows.size(), '{make_req(OP_NOISE_2D, 32'h00FF_8000, 32'h00FF_C000, 0,
                                          24'h010000, 2), 0, none});
      rows.insert(rows.size(), '{make_req(OP_NOISE_3D, 32'hFFFF_8000, 32'h00FF_4000,
                                          32'hFFFF_0001, 24'h010000, 2), 0, none});
      foreach (rows[k]) send_req(rows[k].req, rows[k].typed, rows[k].rsp);
      idle_req(3);

      random_phase(250, 6, 1'b1);

      // Lowest register settings
      write_csr(CSR_PERSISTENCE, 20'd0);
      write_csr(CSR_LACUNARITY, 20'd0);
      random_phase(150, 0, 1'b0);

      // Highest register settings
      write_csr(CSR_PERSISTENCE, 20'd65535);
      write_csr(CSR_LACUNARITY, 20'hFFFFF);
      random_phase(150, 10, 1'b0);

      // Random settings; spare indexes must be ignored
      write_csr(CSR_PERSISTENCE, $urandom_range(0, 20'hFFFFF));
      write_csr(CSR_LACUNARITY, $urandom_range(0, 20'hFFFFF));
      write_csr(CSR_SPARE2, $urandom_range(0, 20'hFFFFF));
      write_csr(CSR_SPARE3, $urandom_range(0, 20'hFFFFF));
      random_phase(250, 4, 1'b1);

      write_csr(CSR_PERSISTENCE, 20'd1);
      write_csr(CSR_LACUNARITY, 20'h10000);
      random_phase(150, 3, 1'b0);

      // Drain and finish
      req_valid <= 1'b0;
      while (pending_noise.size() != 0) @(posedge clock);
      repeat (DRAIN_CYC) @(posedge clock);
      if (error_count == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

   // ---------------- response side ----------------
   int hold_left  = 0;
   int stall_mode = 0;
   int mode_left  = 0;

   // Stall pattern is redrawn whenever its mode counter runs out; long hold on request
   always @(posedge clock) begin
      if (hold_request) begin
         hold_request = 1'b0;
         hold_left    = 3000;
      end
      if (mode_left == 0) begin
         stall_mode = $urandom_range(0, 3);
         mode_left  = $urandom_range(20, 300);
      end else begin
         mode_left--;
      end
      if (reset) begin
         rsp_stall <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left--;
         rsp_stall <= 1'b1;
      end else begin
         case (stall_mode)
            0:       rsp_stall <= 1'b0;
            1:       rsp_stall <= $urandom_range(0, 1);
            2:       rsp_stall <= ($urandom_range(0, 9) == 0);
            default: rsp_stall <= (mode_left % 4 != 0);
         endcase
      end
   end

   // Compare each result transfer with the oldest expectation
   always @(posedge clock) begin
      noise_rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_noise.size() == 0) begin
            $display("%0t: unexpected result noise=%0d sat=%0b", $time,
                     rsp_noise_value, rsp_saturated);
            error_count++;
         end else begin
            want = pending_noise.pop_front();
            if (rsp_noise_value !== want.value) begin
               $display("%0t: noise_value expected %0d actual %0d", $time,
                        want.value, rsp_noise_value);
               error_count++;
            end
            if (rsp_saturated !== want.sat) begin
               $display("%0t: saturated expected %0b actual %0b", $time,
                        want.sat, rsp_saturated);
               error_count++;
            end
         end
      end
   end

   // Watchdog
   initial begin
      #60_000_000;
      $display("TEST FAILED");
      $finish;
   end

endmodule

@@ files.f @@
rtl/fgn_pkg.sv
rtl/fgn_ctrl.sv
rtl/fgn_datapath.sv
rtl/fractal_gradient_noise_unit.sv
sim/tb.sv
